// File: sv/dgcc_pkg.sv
// shared constants and types for the directed graph cycle check
`default_nettype none
package dgcc_pkg;

  // vertex capacity and derived widths
  localparam int MAX_VERTICES = 128;
  localparam int VW           = $clog2(MAX_VERTICES);      // vertex index bits
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);  // count / next-neighbour bits

  // neighbour scan works on fixed slices of an adjacency row
  localparam int CHUNK     = 16;
  localparam int CHUNK_LOG = $clog2(CHUNK);
  localparam int NCHUNK    = MAX_VERTICES / CHUNK;
  localparam int CI_W      = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int CH_W      = $clog2(NCHUNK + 1);

  // one search stack level: vertex and the next neighbour to try
  typedef struct packed {
    logic [VW-1:0]    vertex;
    logic [CNT_W-1:0] next;
  } stk_entry_t;

endpackage
`default_nettype wire

// File: sv/directed_graph_cycle_check.sv
// Directed graph cycle check. Edges (from_vertex, to_vertex) are accepted one per cycle
// and set in an adjacency row memory, one row of MAX_VERTICES bits per source vertex.
// Edges naming vertex 0 or a vertex above vertex_count (capped at MAX_VERTICES) are
// dropped. The transaction with last_edge set starts a depth-first search over vertices
// 1..vertex_count; one has_cycle transaction follows (self-loops count as cycles), after
// which the graph is cleared at once and edges are taken again. The input is not ready
// while the search runs, nor while a finished verdict waits for an earlier one that is
// still held at the output. Search time is set by the single read port of the adjacency
// memory and by the neighbour scan, which looks at 16 bits of a row per cycle. The time
// from the last edge to has_cycle grows with each start vertex tried, each neighbour
// found, each empty 16-bit slice passed, each row end and each return to a parent
// vertex; dense graphs need far more time than sparse ones. The user must write
// vertex_count only while no graph check is in progress; the block itself does not
// enforce this.
`default_nettype none
module directed_graph_cycle_check (
  input  wire logic       clk,
  input  wire logic       rst,
  // configuration
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_data,
  // edge transactions
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] from_vertex,
  input  wire logic [7:0] to_vertex,
  input  wire logic       last_edge,
  // result transactions
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            has_cycle
);

  localparam int MAXV   = dgcc_pkg::MAX_VERTICES;
  localparam int VW     = dgcc_pkg::VW;
  localparam int CNT_W  = dgcc_pkg::CNT_W;
  localparam int CHUNK  = dgcc_pkg::CHUNK;
  localparam int CH_W   = dgcc_pkg::CH_W;
  localparam int CI_W   = dgcc_pkg::CI_W;

  typedef enum logic [2:0] {
    S_LOAD,
    S_DRAIN,
    S_START,
    S_SCAN,
    S_POP,
    S_DONE
  } state_t;

  state_t state;

  // configuration register
  logic [7:0] vertex_count;

  // adjacency memory and per-row valid bits
  logic [MAXV-1:0] adj_mem [MAXV];
  logic [MAXV-1:0] adj_rdata;
  logic            adj_re;
  logic [VW-1:0]   adj_raddr;
  logic            adj_we;
  logic [MAXV-1:0] adj_wdata;
  logic [MAXV-1:0] row_valid;

  // search stack memory
  dgcc_pkg::stk_entry_t stk_mem [MAXV];
  dgcc_pkg::stk_entry_t stk_rdata;
  dgcc_pkg::stk_entry_t stk_wdata;
  logic                 stk_we;
  logic [VW-1:0]        stk_waddr;
  logic                 stk_re;
  logic [VW-1:0]        stk_raddr;

  // edge load pipeline and write-back forwarding
  logic            s1_valid;
  logic [VW-1:0]   s1_row;
  logic [VW-1:0]   s1_col;
  logic            wb_valid;
  logic [VW-1:0]   wb_row;
  logic [MAXV-1:0] wb_data;
  logic [MAXV-1:0] merge_base;

  // search state
  logic [MAXV-1:0]  visited;
  logic [MAXV-1:0]  on_path;
  logic [MAXV-1:0]  nmask;
  logic [CNT_W-1:0] s_cur;
  logic [VW-1:0]    top_vertex;
  logic [CNT_W-1:0] top_next;
  logic [CNT_W-1:0] depth;
  logic [CH_W-1:0]  chunk;
  logic             row_ok;
  logic             cyc_res;

  // combinational helpers
  logic [CNT_W-1:0]  n_eff;
  logic              accept;
  logic              edge_ok;
  logic [MAXV-1:0]   row_data;
  logic [CHUNK-1:0]  chunk_bits;
  logic [CHUNK-1:0]  low_mask;
  logic              chunk_end;
  logic              chunk_hit;
  logic [dgcc_pkg::CHUNK_LOG-1:0] first_idx;
  logic [VW-1:0]     w_idx;
  logic [CNT_W-1:0]  w_next;

  // effective vertex count and edge range check
  assign n_eff   = (32'(vertex_count) > MAXV) ? CNT_W'(MAXV) : CNT_W'(vertex_count);
  assign accept  = in_valid && in_ready;
  assign in_ready = (state == S_LOAD);
  assign edge_ok = (from_vertex != 8'd0) && (32'(from_vertex) <= 32'(n_eff)) &&
                   (to_vertex != 8'd0) && (32'(to_vertex) <= 32'(n_eff));

  // read-modify-write of one adjacency row, forwarding the previous write
  always_comb begin
    if (wb_valid && (wb_row == s1_row)) begin
      merge_base = wb_data;
    end else if (row_valid[s1_row]) begin
      merge_base = adj_rdata;
    end else begin
      merge_base = '0;
    end
    adj_wdata         = merge_base;
    adj_wdata[s1_col] = 1'b1;
  end
  assign adj_we = s1_valid;

  // neighbour scan over one slice of the current row
  assign row_data  = row_ok ? adj_rdata : '0;
  assign chunk_end = (chunk >= CH_W'(dgcc_pkg::NCHUNK));
  assign low_mask  = (chunk == CH_W'(top_next >> dgcc_pkg::CHUNK_LOG)) ?
                     (~CHUNK'(0) << top_next[dgcc_pkg::CHUNK_LOG-1:0]) : ~CHUNK'(0);
  assign chunk_bits = row_data[chunk[CI_W-1:0]*CHUNK +: CHUNK] &
                      nmask[chunk[CI_W-1:0]*CHUNK +: CHUNK] & low_mask;
  assign chunk_hit = !chunk_end && (chunk_bits != '0);

  always_comb begin
    first_idx = '0;
    for (int i = CHUNK - 1; i >= 0; i--) begin
      if (chunk_bits[i]) begin
        first_idx = dgcc_pkg::CHUNK_LOG'(i);
      end
    end
  end
  assign w_idx  = VW'({chunk[CI_W-1:0], first_idx});
  assign w_next = CNT_W'(w_idx) + CNT_W'(1);

  // memory port control
  always_comb begin
    adj_re    = 1'b0;
    adj_raddr = '0;
    stk_we    = 1'b0;
    stk_waddr = '0;
    stk_wdata = '0;
    stk_re    = 1'b0;
    stk_raddr = '0;
    unique case (state)
      S_LOAD: begin
        adj_re    = accept;
        adj_raddr = VW'(from_vertex - 8'd1);
      end
      S_START: begin
        adj_re    = (s_cur < n_eff) && !visited[s_cur[VW-1:0]];
        adj_raddr = s_cur[VW-1:0];
      end
      S_SCAN: begin
        if (chunk_end) begin
          stk_re    = (depth != CNT_W'(1));
          stk_raddr = VW'(depth - CNT_W'(2));
        end else if (chunk_hit && !on_path[w_idx] && !visited[w_idx]) begin
          stk_we           = 1'b1;
          stk_waddr        = VW'(depth - CNT_W'(1));
          stk_wdata.vertex = top_vertex;
          stk_wdata.next   = w_next;
          adj_re           = 1'b1;
          adj_raddr        = w_idx;
        end
      end
      S_POP: begin
        adj_re    = 1'b1;
        adj_raddr = stk_rdata.vertex;
      end
      default: begin
      end
    endcase
  end

  // adjacency memory
  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[s1_row] <= adj_wdata;
    end
    if (adj_re) begin
      adj_rdata <= adj_mem[adj_raddr];
    end
  end

  // stack memory
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rdata <= stk_mem[stk_raddr];
    end
  end

  // edge pipeline payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_row <= VW'(from_vertex - 8'd1);
      s1_col <= VW'(to_vertex - 8'd1);
    end
    if (adj_we) begin
      wb_row  <= s1_row;
      wb_data <= adj_wdata;
    end
  end

  // control state, search state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      vertex_count <= 8'd1;
      s1_valid     <= 1'b0;
      wb_valid     <= 1'b0;
      row_valid    <= '0;
      visited      <= '0;
      on_path      <= '0;
      depth        <= '0;
      out_valid    <= 1'b0;
      has_cycle    <= 1'b0;
    end else begin
      if (cfg_we) begin
        vertex_count <= cfg_data;
      end
      s1_valid <= accept && edge_ok;
      wb_valid <= adj_we;
      if (adj_we) begin
        row_valid[s1_row] <= 1'b1;
      end
      // result taken; a verdict finishing now refills the register below
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_LOAD: begin
          if (accept && last_edge) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          for (int i = 0; i < MAXV; i++) begin
            nmask[i] <= (i < 32'(n_eff));
          end
          s_cur <= '0;
          state <= S_START;
        end
        S_START: begin
          if (s_cur >= n_eff) begin
            cyc_res <= 1'b0;
            state   <= S_DONE;
          end else if (visited[s_cur[VW-1:0]]) begin
            s_cur <= s_cur + CNT_W'(1);
          end else begin
            visited[s_cur[VW-1:0]] <= 1'b1;
            on_path[s_cur[VW-1:0]] <= 1'b1;
            top_vertex <= s_cur[VW-1:0];
            top_next   <= '0;
            depth      <= CNT_W'(1);
            chunk      <= '0;
            row_ok     <= row_valid[s_cur[VW-1:0]];
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (chunk_end) begin
            // no neighbour left: pop this level
            on_path[top_vertex] <= 1'b0;
            depth <= depth - CNT_W'(1);
            if (depth == CNT_W'(1)) begin
              state <= S_START;
            end else begin
              state <= S_POP;
            end
          end else if (!chunk_hit) begin
            chunk <= chunk + CH_W'(1);
          end else if (on_path[w_idx]) begin
            // back edge closes a cycle
            cyc_res <= 1'b1;
            state   <= S_DONE;
          end else if (!visited[w_idx]) begin
            // descend into an unvisited neighbour
            visited[w_idx] <= 1'b1;
            on_path[w_idx] <= 1'b1;
            top_vertex <= w_idx;
            top_next   <= '0;
            depth      <= depth + CNT_W'(1);
            chunk      <= '0;
            row_ok     <= row_valid[w_idx];
          end else begin
            // already finished vertex: move past it
            top_next <= w_next;
            chunk    <= CH_W'(w_next >> dgcc_pkg::CHUNK_LOG);
          end
        end
        S_POP: begin
          top_vertex <= stk_rdata.vertex;
          top_next   <= stk_rdata.next;
          chunk      <= CH_W'(stk_rdata.next >> dgcc_pkg::CHUNK_LOG);
          row_ok     <= row_valid[stk_rdata.vertex];
          state      <= S_SCAN;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            has_cycle <= cyc_res;
            visited   <= '0;
            on_path   <= '0;
            row_valid <= '0;
            depth     <= '0;
            state     <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // stack depth stays within capacity
  a_depth_cap: assert property (@(posedge clk) disable iff (rst)
    32'(depth) <= MAXV)
    else $error("search stack depth above capacity");

  // the vertex being scanned is always on the current path
  a_top_on_path: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (on_path[top_vertex] && (depth != '0)))
    else $error("scanned vertex not on path");

  // a new result always leaves a cleared graph behind
  a_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!out_valid || out_ready)) |=>
      (visited == '0 && on_path == '0 && row_valid == '0 && out_valid))
    else $error("graph not cleared with result");

  // no edge write lands while the search reads the adjacency memory
  a_no_write_in_search: assert property (@(posedge clk) disable iff (rst)
    (state == S_START || state == S_SCAN || state == S_POP) |-> !s1_valid)
    else $error("edge write during search");

endmodule
`default_nettype wire

// File: bench/directed_graph_cycle_check_tb.sv
// self-checking testbench for the directed graph cycle check block
`default_nettype none
module directed_graph_cycle_check_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_VERTICES = dgcc_pkg::MAX_VERTICES;

  // cycles to wait after the last verdict before touching the count register
  localparam int QUIET_CYCLES  = 16;
  localparam int RANDOM_EDGES  = 450;
  localparam int STALL_CYCLES  = 400;
  localparam int STALL_AFTER   = 25;

  // predicts the has_cycle verdict of each graph and checks the block against it
  class cycle_scoreboard;
    bit [MAX_VERTICES-1:0] adj_rows [MAX_VERTICES];
    int unsigned vertex_limit;
    bit          verdicts [$];
    int          errors;
    int          edges_taken;
    int          checks;
    int          cycles_seen;

    function new();
      clear_graph();
      vertex_limit = 1;
    endfunction

    function void clear_graph();
      foreach (adj_rows[i]) adj_rows[i] = '0;
    endfunction

    // count register write, clamped to the vertex capacity
    function void set_count(logic [7:0] value);
      vertex_limit = (value > MAX_VERTICES) ? MAX_VERTICES : value;
    endfunction

    // depth-first search with an explicit trail, vertices 0..limit-1
    function bit find_cycle();
      bit seen       [MAX_VERTICES];
      bit on_trail   [MAX_VERTICES];
      int trail_vtx  [MAX_VERTICES];
      int trail_next [MAX_VERTICES];
      int depth;
      int v;
      int w;
      int n;
      n = vertex_limit;
      for (int s = 0; s < n; s++) begin
        if (seen[s]) continue;
        seen[s] = 1'b1;
        on_trail[s] = 1'b1;
        trail_vtx[0] = s;
        trail_next[0] = 0;
        depth = 1;
        while (depth > 0) begin
          v = trail_vtx[depth-1];
          w = trail_next[depth-1];
          while (w < n && !adj_rows[v][w]) w++;
          if (w >= n) begin
            on_trail[v] = 1'b0;
            depth--;
            continue;
          end
          trail_next[depth-1] = w + 1;
          if (on_trail[w]) return 1'b1;
          if (!seen[w] && depth < MAX_VERTICES) begin
            seen[w] = 1'b1;
            on_trail[w] = 1'b1;
            trail_vtx[depth] = w;
            trail_next[depth] = 0;
            depth++;
          end
        end
      end
      return 1'b0;
    endfunction

    // accepted edge transaction: store it, and on the last edge predict the verdict
    function void record_edge(logic [7:0] src, logic [7:0] dst, logic last);
      bit verdict;
      edges_taken++;
      if (src >= 1 && src <= vertex_limit && dst >= 1 && dst <= vertex_limit)
        adj_rows[src-1][dst-1] = 1'b1;
      if (last) begin
        verdict = find_cycle();
        verdicts = {verdicts, verdict};
        clear_graph();
      end
    endfunction

    // accepted result transaction against the oldest prediction
    function void check_verdict(logic actual);
      bit want;
      checks++;
      if (actual) cycles_seen++;
      if (verdicts.size() == 0) begin
        $error("has_cycle: unexpected result, expected none, actual %0b", actual);
        errors++;
      end else begin
        want = verdicts.pop_front();
        if (actual !== want) begin
          $error("has_cycle mismatch: expected %0b, actual %0b", want, actual);
          errors++;
        end
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] from_vertex;
  logic [7:0] to_vertex;
  logic       last_edge;
  logic       out_valid;
  logic       out_ready;
  logic       has_cycle;

  cycle_scoreboard sb = new();
  bit steady;
  bit holding;
  bit stall_done;
  int count_writes;

  directed_graph_cycle_check u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .from_vertex (from_vertex),
    .to_vertex   (to_vertex),
    .last_edge   (last_edge),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .has_cycle   (has_cycle)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #10ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_verdict(has_cycle);
  end

  // receiver: random back-pressure plus one long hold-off
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        out_ready <= 1'b0;
      end else if (!stall_done && sb.checks >= STALL_AFTER) begin
        stall_done = 1'b1;
        holding = 1'b1;
        out_ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        holding = 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 20);
      end
    end
  end

  // offer one edge transaction and wait for it to be taken
  task automatic send_edge(logic [7:0] src, logic [7:0] dst, logic last);
    if (!steady && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    from_vertex <= src;
    to_vertex   <= dst;
    last_edge   <= last;
    do @(posedge clk); while (!in_ready);
    sb.record_edge(src, dst, last);
  endtask

  task automatic wait_drained();
    while (sb.verdicts.size() != 0) @(posedge clk);
  endtask

  // count register write with the block idle
  task automatic set_vertex_count(logic [7:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    wait_drained();
    repeat (QUIET_CYCLES) @(posedge clk);
    cfg_data <= value;
    cfg_we   <= 1'b1;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.set_count(value);
    count_writes++;
  endtask

  // random graph: acyclic, arbitrary, or acyclic with a back edge, some noise
  task automatic random_graph();
    int r;
    int n;
    int num;
    int shape;
    int back_at;
    logic [7:0] value;
    logic [7:0] src;
    logic [7:0] dst;
    if (!holding && $urandom_range(99) < 35) begin
      r = $urandom_range(99);
      if (r < 6) value = 8'd0;
      else if (r < 14) value = 8'($urandom_range(129, 255));
      else if (r < 22) value = 8'(MAX_VERTICES);
      else if (r < 30) value = 8'($urandom_range(11, 127));
      else value = 8'($urandom_range(1, 10));
      set_vertex_count(value);
    end
    n = sb.vertex_limit;
    num = (n >= 32) ? $urandom_range(1, 24) : $urandom_range(1, (2 * n + 1 > 16) ? 16 : 2 * n + 1);
    shape = $urandom_range(2);
    back_at = $urandom_range(0, num - 1);
    for (int i = 0; i < num; i++) begin
      if (n == 0 || $urandom_range(99) < 10) begin
        src = 8'($urandom_range(0, 255));
        dst = 8'($urandom_range(0, 255));
      end else if (n < 2 || shape == 1) begin
        src = 8'($urandom_range(1, n));
        dst = 8'($urandom_range(1, n));
      end else begin
        src = 8'($urandom_range(1, n - 1));
        dst = 8'($urandom_range(src + 1, n));
        // reversed edge may close a loop
        if (shape == 2 && i == back_at) begin
          {src, dst} = {dst, src};
          if ($urandom_range(3) == 0) dst = src;
        end
      end
      send_edge(src, dst, i == num - 1);
    end
  endtask

  // stimulus
  initial begin
    int random_start;
    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_data    <= 8'd0;
    in_valid    <= 1'b0;
    from_vertex <= 8'd0;
    to_vertex   <= 8'd0;
    last_edge   <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset count of one: self-loop on the only vertex
    send_edge(8'd1, 8'd1, 1'b1);

    // count of zero: every edge ignored
    set_vertex_count(8'd0);
    send_edge(8'd1, 8'd1, 1'b1);

    // count above capacity acts as full capacity; out-of-range vertices dropped
    set_vertex_count(8'd255);
    send_edge(8'd0, 8'd255, 1'b0);
    send_edge(8'd255, 8'd3, 1'b0);
    send_edge(8'd128, 8'd1, 1'b0);
    send_edge(8'd1, 8'd128, 1'b1);

    // small triangle, last edge out of range but still starts the check
    set_vertex_count(8'd3);
    send_edge(8'd1, 8'd2, 1'b0);
    send_edge(8'd2, 8'd3, 1'b0);
    send_edge(8'd3, 8'd1, 1'b0);
    send_edge(8'd3, 8'd4, 1'b1);

    // duplicate edges on an acyclic path
    send_edge(8'd1, 8'd2, 1'b0);
    send_edge(8'd1, 8'd2, 1'b0);
    send_edge(8'd2, 8'd3, 1'b1);

    // loop among high vertices, then the count lowered below them
    set_vertex_count(8'd10);
    send_edge(8'd8, 8'd9, 1'b0);
    send_edge(8'd9, 8'd10, 1'b0);
    send_edge(8'd10, 8'd8, 1'b0);
    set_vertex_count(8'd5);
    send_edge(8'd1, 8'd2, 1'b1);

    // full capacity, self-loop on the top vertex
    set_vertex_count(8'd128);
    send_edge(8'd128, 8'd128, 1'b1);

    // random graphs, with a stretch of no idling on either side
    random_start = sb.edges_taken;
    for (int g = 0; sb.edges_taken - random_start < RANDOM_EDGES; g++) begin
      steady = (g >= 15 && g < 30);
      random_graph();
    end
    steady = 1'b0;

    in_valid <= 1'b0;
    @(posedge clk);
    wait_drained();
    repeat (50) @(posedge clk);

    $display("Covered %0d edge transactions, %0d graph checks (%0d with a cycle)",
             sb.edges_taken, sb.checks, sb.cycles_seen);
    $display("Vertex count written %0d times, from zero to above capacity", count_writes);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
